>>> hw/rtl/fbrc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbrc_pkg
// Shared types and constants of the framed byte receiver with 7-bit checksum.
// ----------------------------------------------------------------------------
package fbrc_pkg;

  // Default sizes
  localparam int CHANNELS_DEF  = 16;
  localparam int MAX_FRAME_DEF = 64;

  // Field widths
  localparam int BYTE_W   = 8;
  localparam int CHAN_W   = 4;
  localparam int SRC_W    = 2;
  localparam int POS_W    = 6;
  localparam int LEN_W    = 7;
  localparam int HDR_W    = 3 * BYTE_W;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = BYTE_W;
  localparam logic [CFG_IDX_W-1:0] REG_HEAD_BYTE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_END_BYTE  = 1'b1;
  localparam logic [BYTE_W-1:0]    HEAD_BYTE_RST = 8'd240;
  localparam logic [BYTE_W-1:0]    END_BYTE_RST  = 8'd247;

  // Checksum covers the low seven bits of the sum
  localparam logic [6:0] CKSUM_MASK = 7'h7f;

  // Saturation limits of the reported position and length
  localparam logic [POS_W-1:0] POS_MAX = '1;
  localparam logic [LEN_W-1:0] LEN_MAX = '1;

  // One result transaction
  typedef struct packed {
    logic [CHAN_W-1:0] out_channel;
    logic [SRC_W-1:0]  out_source;
    logic [BYTE_W-1:0] data_byte;
    logic [POS_W-1:0]  position;
    logic              frame_start;
    logic              frame_last;
    logic              checksum_good;
    logic              overflow;
    logic [LEN_W-1:0]  frame_length;
    logic [BYTE_W-1:0] hdr_byte1;
    logic [BYTE_W-1:0] hdr_byte2;
    logic [BYTE_W-1:0] hdr_byte3;
  } fbrc_result_t;

  // Decisions of the per-byte update
  typedef struct packed {
    logic has_result;
    logic mem_write;
    logic frame_open;
    logic frame_close;
  } fbrc_ctrl_t;

endpackage

>>> hw/rtl/fbrc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbrc interfaces
// Valid/ready channels for received bytes and for reported results.
// ----------------------------------------------------------------------------
interface fbrc_rx_if
  import fbrc_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;
  logic [CHAN_W-1:0] channel;
  logic [SRC_W-1:0]  source_tag;

  modport source (output valid, output rx_byte, output channel, output source_tag,
                  input ready);
  modport sink (input valid, input rx_byte, input channel, input source_tag,
                output ready);
endinterface

interface fbrc_res_if
  import fbrc_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] out_channel;
  logic [SRC_W-1:0]  out_source;
  logic [BYTE_W-1:0] data_byte;
  logic [POS_W-1:0]  position;
  logic              frame_start;
  logic              frame_last;
  logic              checksum_good;
  logic              overflow;
  logic [LEN_W-1:0]  frame_length;
  logic [BYTE_W-1:0] hdr_byte1;
  logic [BYTE_W-1:0] hdr_byte2;
  logic [BYTE_W-1:0] hdr_byte3;

  modport source (output valid, output out_channel, output out_source,
                  output data_byte, output position, output frame_start,
                  output frame_last, output checksum_good, output overflow,
                  output frame_length, output hdr_byte1, output hdr_byte2,
                  output hdr_byte3, input ready);
  modport sink (input valid, input out_channel, input out_source,
                input data_byte, input position, input frame_start,
                input frame_last, input checksum_good, input overflow,
                input frame_length, input hdr_byte1, input hdr_byte2,
                input hdr_byte3, output ready);
endinterface

>>> hw/rtl/framed_byte_receiver_checksum7.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framed_byte_receiver_checksum7
// Per-channel head/end delimited frame receiver with a 7-bit sum checksum.
//
//   port     | dir  | transaction
//   ---------+------+---------------------------------------------------
//   stream   | in   | one received byte with channel and source tag
//   report   | out  | zero or one result per byte, registered
//   cfg_*    | in   | write of head_byte (index 0) or end_byte (index 1)
//
// One byte per cycle sustained; a result is registered after the update stage.
// Frame state lives in one RAM read in the accept cycle and written back by
// the update stage; the last write is forwarded to cover back-to-back bytes on
// a channel. Open-frame flags are flip-flops cleared by reset, so no clearing
// pass is needed. A stalled report holds the update stage and then stream.
// ----------------------------------------------------------------------------
module framed_byte_receiver_checksum7
  import fbrc_pkg::*;
#(
  parameter int CHANNELS  = CHANNELS_DEF,
  parameter int MAX_FRAME = MAX_FRAME_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  fbrc_rx_if.sink               stream,
  fbrc_res_if.source            report,
  input  logic                  cfg_wen,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int ADDR_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CNT_W   = $clog2(MAX_FRAME + 1);
  localparam int ENTRY_W = CNT_W + 2 * BYTE_W + HDR_W;
  localparam int CHX_W   = CHAN_W + ADDR_W + 1;

  // Configuration registers
  logic [BYTE_W-1:0] head_byte;
  logic [BYTE_W-1:0] end_byte;

  // Update stage
  logic              s1_valid;
  logic [BYTE_W-1:0] s1_byte;
  logic [CHAN_W-1:0] s1_channel;
  logic [SRC_W-1:0]  s1_source;
  logic              s1_adv;
  logic              accept;

  // Open-frame flags
  logic [CHANNELS-1:0] in_frame;

  // Frame state RAM and forwarding
  logic [ENTRY_W-1:0] rd_entry;
  logic [ENTRY_W-1:0] entry;
  logic [ENTRY_W-1:0] wr_entry;
  logic               wr_en;
  logic               last_wr_valid;
  logic [ADDR_W-1:0]  last_wr_addr;
  logic [ENTRY_W-1:0] last_wr_entry;

  logic [CHX_W-1:0]   in_ch_ext;
  logic [CHX_W-1:0]   s1_ch_ext;
  logic [ADDR_W-1:0]  rd_addr;
  logic [ADDR_W-1:0]  s1_addr;
  logic               s1_in_range;

  logic [CNT_W-1:0]   cur_count;
  logic [BYTE_W-1:0]  cur_sum;
  logic [BYTE_W-1:0]  cur_prev;
  logic [HDR_W-1:0]   cur_hdr;
  logic [CNT_W-1:0]   count_next;
  logic [BYTE_W-1:0]  sum_next;
  logic [BYTE_W-1:0]  prev_next;
  logic [HDR_W-1:0]   hdr_next;

  fbrc_ctrl_t   ctrl;
  fbrc_result_t step_result;

  // Output register
  logic         out_valid;
  fbrc_result_t out_data;

  // Handshake
  assign s1_adv       = s1_valid && (!out_valid || report.ready);
  assign stream.ready = !s1_valid || s1_adv;
  assign accept       = stream.valid && stream.ready;

  // Channel to RAM address
  assign in_ch_ext   = {{(ADDR_W+1){1'b0}}, stream.channel};
  assign s1_ch_ext   = {{(ADDR_W+1){1'b0}}, s1_channel};
  assign rd_addr     = in_ch_ext[ADDR_W-1:0];
  assign s1_addr     = s1_ch_ext[ADDR_W-1:0];
  assign s1_in_range = (s1_ch_ext < CHX_W'(CHANNELS));

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      head_byte <= HEAD_BYTE_RST;
      end_byte  <= END_BYTE_RST;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_HEAD_BYTE: head_byte <= cfg_data;
        REG_END_BYTE:  end_byte  <= cfg_data;
        default:       ;
      endcase
    end
  end

  // Advance the update stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (stream.ready) begin
      s1_valid <= stream.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_byte    <= stream.rx_byte;
      s1_channel <= stream.channel;
      s1_source  <= stream.source_tag;
    end
  end

  fbrc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CHANNELS)
  ) u_state_ram (
    .clk   (clk),
    .wen   (wr_en),
    .waddr (s1_addr),
    .wdata (wr_entry),
    .ren   (accept),
    .raddr (rd_addr),
    .rdata (rd_entry)
  );

  // Forward the write that shared an edge with this read
  assign entry = (last_wr_valid && (last_wr_addr == s1_addr)) ? last_wr_entry : rd_entry;
  assign {cur_count, cur_sum, cur_prev, cur_hdr} = entry;

  fbrc_frame_step #(
    .MAX_FRAME (MAX_FRAME)
  ) u_step (
    .rx_byte    (s1_byte),
    .channel    (s1_channel),
    .source_tag (s1_source),
    .in_range   (s1_in_range),
    .in_frame   (s1_in_range && in_frame[s1_addr]),
    .count      (cur_count),
    .sum        (cur_sum),
    .prev       (cur_prev),
    .hdr        (cur_hdr),
    .head_byte  (head_byte),
    .end_byte   (end_byte),
    .ctrl       (ctrl),
    .result     (step_result),
    .count_next (count_next),
    .sum_next   (sum_next),
    .prev_next  (prev_next),
    .hdr_next   (hdr_next)
  );

  assign wr_en    = s1_adv && ctrl.mem_write;
  assign wr_entry = {count_next, sum_next, prev_next, hdr_next};

  // Remember the last write for forwarding
  always_ff @(posedge clk) begin
    if (rst) begin
      last_wr_valid <= 1'b0;
    end else if (wr_en) begin
      last_wr_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      last_wr_addr  <= s1_addr;
      last_wr_entry <= wr_entry;
    end
  end

  // Open and close frames
  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame <= '0;
    end else if (s1_adv && s1_in_range) begin
      if (ctrl.frame_open) begin
        in_frame[s1_addr] <= 1'b1;
      end else if (ctrl.frame_close) begin
        in_frame[s1_addr] <= 1'b0;
      end
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= ctrl.has_result;
    end else if (report.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && ctrl.has_result) begin
      out_data <= step_result;
    end
  end

  assign report.valid         = out_valid;
  assign report.out_channel   = out_data.out_channel;
  assign report.out_source    = out_data.out_source;
  assign report.data_byte     = out_data.data_byte;
  assign report.position      = out_data.position;
  assign report.frame_start   = out_data.frame_start;
  assign report.frame_last    = out_data.frame_last;
  assign report.checksum_good = out_data.checksum_good;
  assign report.overflow      = out_data.overflow;
  assign report.frame_length  = out_data.frame_length;
  assign report.hdr_byte1     = out_data.hdr_byte1;
  assign report.hdr_byte2     = out_data.hdr_byte2;
  assign report.hdr_byte3     = out_data.hdr_byte3;

endmodule

>>> hw/rtl/fbrc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbrc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fbrc_ram #(
  parameter int  WIDTH  = 8,
  parameter int  DEPTH  = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wen,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              ren,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, old data on a same-address write
  always_ff @(posedge clk) begin
    if (ren) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/fbrc_frame_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbrc_frame_step
// Per-byte frame update: head/end detection, checksum, length limit, result.
// ----------------------------------------------------------------------------
module fbrc_frame_step
  import fbrc_pkg::*;
#(
  parameter int  MAX_FRAME = MAX_FRAME_DEF,
  localparam int CNT_W     = $clog2(MAX_FRAME + 1)
) (
  input  logic [BYTE_W-1:0] rx_byte,
  input  logic [CHAN_W-1:0] channel,
  input  logic [SRC_W-1:0]  source_tag,
  input  logic              in_range,
  input  logic              in_frame,
  input  logic [CNT_W-1:0]  count,
  input  logic [BYTE_W-1:0] sum,
  input  logic [BYTE_W-1:0] prev,
  input  logic [HDR_W-1:0]  hdr,
  input  logic [BYTE_W-1:0] head_byte,
  input  logic [BYTE_W-1:0] end_byte,
  output fbrc_ctrl_t        ctrl,
  output fbrc_result_t      result,
  output logic [CNT_W-1:0]  count_next,
  output logic [BYTE_W-1:0] sum_next,
  output logic [BYTE_W-1:0] prev_next,
  output logic [HDR_W-1:0]  hdr_next
);

  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_FRAME);
  localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_TWO   = CNT_W'(2);
  localparam logic [CNT_W-1:0] CNT_THREE = CNT_W'(3);

  logic                    is_head;
  logic                    is_end;
  logic                    at_limit;
  logic [CNT_W-1:0]        count_inc;
  logic [CNT_W+LEN_W-1:0]  pos_ext;
  logic [CNT_W+LEN_W-1:0]  len_ext;
  logic [POS_W-1:0]        pos_sat;
  logic [LEN_W-1:0]        len_sat;
  logic [HDR_W-1:0]        hdr_upd;
  logic [BYTE_W-1:0]       body_sum;
  logic                    sum_match;

  assign is_head   = (rx_byte == head_byte);
  assign is_end    = (rx_byte == end_byte);
  assign at_limit  = (count >= CNT_LIMIT);
  assign count_inc = count + CNT_ONE;

  // Saturate position and length to their field widths
  assign pos_ext = {{LEN_W{1'b0}}, count};
  assign len_ext = {{LEN_W{1'b0}}, (at_limit ? CNT_LIMIT : count_inc)};
  assign pos_sat = (pos_ext > (CNT_W+LEN_W)'(POS_MAX)) ? POS_MAX : pos_ext[POS_W-1:0];
  assign len_sat = (len_ext > (CNT_W+LEN_W)'(LEN_MAX)) ? LEN_MAX : len_ext[LEN_W-1:0];

  // Capture frame bytes one to three
  always_comb begin
    hdr_upd = hdr;
    if (count == CNT_ONE) begin
      hdr_upd[7:0] = hdr[7:0] | rx_byte;
    end else if (count == CNT_TWO) begin
      hdr_upd[15:8] = hdr[15:8] | rx_byte;
    end else if (count == CNT_THREE) begin
      hdr_upd[23:16] = hdr[23:16] | rx_byte;
    end
  end

  // Sum of the body without the checksum byte, low seven bits
  assign body_sum  = sum - prev;
  assign sum_match = ({1'b0, body_sum[6:0] & CKSUM_MASK} == prev);

  // Decide the transaction and the new entry
  always_comb begin
    ctrl       = '0;
    count_next = count_inc;
    sum_next   = sum + rx_byte;
    prev_next  = rx_byte;
    hdr_next   = hdr_upd;

    result               = '0;
    result.out_channel   = channel;
    result.out_source    = source_tag;
    result.data_byte     = rx_byte;
    result.position      = pos_sat;
    result.frame_length  = len_sat;

    if (in_range && is_head) begin
      // Restart the frame
      ctrl.has_result     = 1'b1;
      ctrl.mem_write      = 1'b1;
      ctrl.frame_open     = 1'b1;
      count_next          = CNT_ONE;
      sum_next            = '0;
      hdr_next            = '0;
      result.frame_start  = 1'b1;
      result.position     = '0;
      result.frame_length = LEN_W'(1);
    end else if (in_range && in_frame) begin
      ctrl.has_result = 1'b1;
      if (at_limit) begin
        // Drop the frame that grew past the limit
        ctrl.frame_close  = 1'b1;
        result.overflow   = 1'b1;
        result.frame_last = 1'b1;
        result.hdr_byte1  = hdr[7:0];
        result.hdr_byte2  = hdr[15:8];
        result.hdr_byte3  = hdr[23:16];
      end else begin
        ctrl.mem_write = 1'b1;
        if (is_end) begin
          ctrl.frame_close     = 1'b1;
          result.frame_last    = 1'b1;
          result.checksum_good = (count >= CNT_TWO) && sum_match;
          result.hdr_byte1     = hdr_upd[7:0];
          result.hdr_byte2     = hdr_upd[15:8];
          result.hdr_byte3     = hdr_upd[23:16];
        end
      end
    end
  end

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for framed_byte_receiver_checksum7. Bytes are sent on
// several channels at once. Most of them form frames: clean frames, frames
// with a bad checksum, short frames, abandoned frames and frames that run past
// the length limit. A cycle-free tracker of the per-channel frame state
// predicts each report, and every report is checked in order against it. The
// head and end bytes are changed between phases, extreme values included.
// ----------------------------------------------------------------------------
module testbench
  import fbrc_pkg::*;
;

  localparam int LANES          = 4;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int SETTLE_CYCLES  = 8;

  logic clk;
  logic rst;
  logic                  cfg_wen;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  fbrc_rx_if  stream_if ();
  fbrc_res_if report_if ();

  framed_byte_receiver_checksum7 dut (
    .clk       (clk),
    .rst       (rst),
    .stream    (stream_if),
    .report    (report_if),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Tracked copy of the registers and of the per-channel frame state
  logic [BYTE_W-1:0] head_cfg;
  logic [BYTE_W-1:0] end_cfg;
  logic              frame_open  [CHANNELS_DEF];
  int                frame_count [CHANNELS_DEF];
  logic [BYTE_W-1:0] frame_sum   [CHANNELS_DEF];
  logic [BYTE_W-1:0] last_byte   [CHANNELS_DEF];
  logic [HDR_W-1:0]  header_ids  [CHANNELS_DEF];

  fbrc_result_t      pending_reports [$];
  int                reported_items = 0;
  int                mismatches     = 0;
  int                quiet_cycles   = 0;

  // Traffic lanes: each lane feeds one channel at a time with frame bytes
  logic [BYTE_W-1:0] lane_bytes [LANES][$];
  logic [CHAN_W-1:0] lane_chan  [LANES];

  bit gaps_on     = 1'b0;
  bit idle_enable = 1'b1;
  int stall_left  = 0;

  // Update the frame state for one accepted byte; return 1 when it is reported
  function automatic bit track_byte(input logic [BYTE_W-1:0] b,
                                    input logic [CHAN_W-1:0] ch,
                                    input logic [SRC_W-1:0] src,
                                    output fbrc_result_t r);
    int idx;
    logic [BYTE_W-1:0] chk;
    logic [6:0] body;
    r = '0;
    r.out_channel = ch;
    r.out_source  = src;
    r.data_byte   = b;
    // A head byte restarts the frame, also inside an open one
    if (b == head_cfg) begin
      frame_open[ch]  = 1'b1;
      frame_count[ch] = 1;
      frame_sum[ch]   = '0;
      last_byte[ch]   = b;
      header_ids[ch]  = '0;
      r.frame_start   = 1'b1;
      r.frame_length  = LEN_W'(1);
      return 1'b1;
    end
    // Drop bytes outside a frame
    if (!frame_open[ch]) return 1'b0;
    idx = frame_count[ch];
    r.position = (idx > int'(POS_MAX)) ? POS_MAX : POS_W'(idx);
    // Past the length limit: report, flag and close without counting the byte
    if (idx >= MAX_FRAME_DEF) begin
      r.overflow     = 1'b1;
      r.frame_last   = 1'b1;
      r.frame_length = LEN_W'(MAX_FRAME_DEF);
      {r.hdr_byte3, r.hdr_byte2, r.hdr_byte1} = header_ids[ch];
      frame_open[ch] = 1'b0;
      return 1'b1;
    end
    r.frame_length = LEN_W'(idx + 1);
    if (idx >= 1 && idx <= 3)
      header_ids[ch] = header_ids[ch] | (HDR_W'(b) << (8 * (idx - 1)));
    // End byte: the byte before it is the checksum over the body
    if (b == end_cfg) begin
      chk = last_byte[ch];
      body = 7'(frame_sum[ch] - chk);
      r.frame_last    = 1'b1;
      r.checksum_good = (idx >= 2) && ({1'b0, body} == chk);
      {r.hdr_byte3, r.hdr_byte2, r.hdr_byte1} = header_ids[ch];
      frame_open[ch] = 1'b0;
    end
    frame_sum[ch]   = frame_sum[ch] + b;
    last_byte[ch]   = b;
    frame_count[ch] = idx + 1;
    return 1'b1;
  endfunction

  function automatic string result_text(input fbrc_result_t r);
    return $sformatf({"ch=%0d src=%0d byte=%02h pos=%0d start=%b last=%b good=%b ",
                      "ovf=%b len=%0d hb1=%02h hb2=%02h hb3=%02h"},
                     r.out_channel, r.out_source, r.data_byte, r.position,
                     r.frame_start, r.frame_last, r.checksum_good, r.overflow,
                     r.frame_length, r.hdr_byte1, r.hdr_byte2, r.hdr_byte3);
  endfunction

  // A random byte that neither starts nor ends a frame
  function automatic logic [BYTE_W-1:0] payload_byte();
    logic [BYTE_W-1:0] v;
    do v = BYTE_W'($urandom); while (v == head_cfg || v == end_cfg);
    return v;
  endfunction

  // Send one byte; return at the falling edge after the transaction
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic [CHAN_W-1:0] ch,
                           input logic [SRC_W-1:0] src);
    fbrc_result_t r;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      stream_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    stream_if.valid      <= 1'b1;
    stream_if.rx_byte    <= b;
    stream_if.channel    <= ch;
    stream_if.source_tag <= src;
    @(posedge clk);
    while (!stream_if.ready) @(posedge clk);
    if (track_byte(b, ch, src, r)) begin
      pending_reports.push_back(r);
      reported_items++;
    end
    @(negedge clk);
  endtask

  // Hold the stream until every report is in and the pipeline has settled
  task automatic drain_pipeline();
    stream_if.valid <= 1'b0;
    while (pending_reports.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_wen <= 1'b0;
    if (idx == REG_HEAD_BYTE) head_cfg = val;
    else end_cfg = val;
    @(negedge clk);
  endtask

  // Queue one byte sequence on a lane: mostly frames, some noise
  task automatic build_frame(input int lane);
    int kind;
    int n;
    logic [BYTE_W-1:0] v;
    logic [BYTE_W-1:0] sum;
    kind = $urandom_range(0, 99);
    sum = '0;
    if (kind >= 85) begin
      repeat ($urandom_range(1, 6)) lane_bytes[lane].push_back(BYTE_W'($urandom));
      return;
    end
    lane_bytes[lane].push_back(head_cfg);
    // Fill the frame to the length limit, then one more byte, sometimes the end byte
    if (kind >= 80) begin
      repeat (MAX_FRAME_DEF - 1) lane_bytes[lane].push_back(payload_byte());
      lane_bytes[lane].push_back($urandom_range(0, 1) ? end_cfg : payload_byte());
      return;
    end
    // Too short: head then end, or a single byte between them
    if (kind >= 74) begin
      if ($urandom_range(0, 1)) lane_bytes[lane].push_back(payload_byte());
      lane_bytes[lane].push_back(end_cfg);
      return;
    end
    n = ($urandom_range(0, 19) == 0) ? $urandom_range(9, MAX_FRAME_DEF - 3)
                                     : $urandom_range(0, 8);
    for (int i = 0; i < n; i++) begin
      v = payload_byte();
      sum = sum + v;
      lane_bytes[lane].push_back(v);
    end
    // Abandoned frame: the next head restarts it
    if (kind >= 68) return;
    v = {1'b0, sum[6:0]};
    if (kind >= 60) v = v ^ (BYTE_W'(1) << $urandom_range(0, 7));
    lane_bytes[lane].push_back(v);
    lane_bytes[lane].push_back(end_cfg);
  endtask

  // Interleave lanes until the given number of reports has been predicted
  task automatic run_traffic(input int target);
    int lane;
    int goal;
    goal = reported_items + target;
    lane = 0;
    while (reported_items < goal) begin
      if ($urandom_range(0, 1) == 0) lane = $urandom_range(0, LANES - 1);
      if (lane_bytes[lane].size() == 0) begin
        lane_chan[lane] = CHAN_W'(lane + LANES * $urandom_range(0, 3));
        build_frame(lane);
      end
      send_byte(lane_bytes[lane].pop_front(), lane_chan[lane], SRC_W'($urandom));
      if ($urandom_range(0, 63) == 0) gaps_on = idle_enable && ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 255) == 0) drain_pipeline();
    end
    for (int i = 0; i < LANES; i++) lane_bytes[i].delete();
  endtask

  // Extremes of each field and the named corner cases at reset settings
  task automatic test_directed();
    // clean frame with header ids 1, 2, 3
    send_byte(HEAD_BYTE_RST, 4'd0, 2'd0);
    send_byte(8'h01, 4'd0, 2'd0);
    send_byte(8'h02, 4'd0, 2'd0);
    send_byte(8'h03, 4'd0, 2'd0);
    send_byte(8'h06, 4'd0, 2'd0);
    send_byte(END_BYTE_RST, 4'd0, 2'd0);
    // head then end
    send_byte(HEAD_BYTE_RST, 4'd1, 2'd1);
    send_byte(END_BYTE_RST, 4'd1, 2'd1);
    // one byte between head and end
    send_byte(HEAD_BYTE_RST, 4'd2, 2'd2);
    send_byte(8'h00, 4'd2, 2'd2);
    send_byte(END_BYTE_RST, 4'd2, 2'd2);
    // bytes with no open frame
    send_byte(8'h55, 4'd3, 2'd0);
    send_byte(8'hff, 4'd15, 2'd3);
    // head inside an open frame
    send_byte(HEAD_BYTE_RST, 4'd4, 2'd1);
    send_byte(8'h10, 4'd4, 2'd1);
    send_byte(HEAD_BYTE_RST, 4'd4, 2'd1);
    send_byte(8'h7f, 4'd4, 2'd1);
    send_byte(END_BYTE_RST, 4'd4, 2'd1);
    // all-ones and all-zeros body bytes
    send_byte(HEAD_BYTE_RST, 4'd15, 2'd3);
    send_byte(8'hff, 4'd15, 2'd3);
    send_byte(8'h00, 4'd15, 2'd3);
    send_byte(8'h7f, 4'd15, 2'd3);
    send_byte(END_BYTE_RST, 4'd15, 2'd3);
  endtask

  // A frame of exactly the limit, then one that runs past it
  task automatic test_length_limit();
    logic [BYTE_W-1:0] v;
    logic [BYTE_W-1:0] sum;
    sum = '0;
    send_byte(head_cfg, 4'd9, 2'd2);
    repeat (MAX_FRAME_DEF - 3) begin
      v = payload_byte();
      sum = sum + v;
      send_byte(v, 4'd9, 2'd2);
    end
    send_byte({1'b0, sum[6:0]}, 4'd9, 2'd2);
    send_byte(end_cfg, 4'd9, 2'd2);
    send_byte(head_cfg, 4'd9, 2'd1);
    repeat (MAX_FRAME_DEF - 1) send_byte(payload_byte(), 4'd9, 2'd1);
    send_byte(end_cfg, 4'd9, 2'd1);
    send_byte(payload_byte(), 4'd9, 2'd1);
  endtask

  // Traffic under extreme, equal and random head/end values
  task automatic test_register_settings();
    drain_pipeline();
    write_reg(REG_HEAD_BYTE, 8'h00);
    write_reg(REG_END_BYTE, 8'hff);
    run_traffic(150);
    drain_pipeline();
    write_reg(REG_HEAD_BYTE, 8'hff);
    write_reg(REG_END_BYTE, 8'h00);
    run_traffic(150);
    drain_pipeline();
    write_reg(REG_HEAD_BYTE, 8'h5a);
    write_reg(REG_END_BYTE, 8'h5a);
    run_traffic(150);
    repeat (2) begin
      drain_pipeline();
      write_reg(REG_HEAD_BYTE, BYTE_W'($urandom));
      write_reg(REG_END_BYTE, BYTE_W'($urandom));
      run_traffic(150);
    end
  endtask

  // Long random run at reset values, the last part without idling
  task automatic test_random_traffic();
    drain_pipeline();
    write_reg(REG_HEAD_BYTE, HEAD_BYTE_RST);
    write_reg(REG_END_BYTE, END_BYTE_RST);
    run_traffic(500);
    drain_pipeline();
    idle_enable = 1'b0;
    gaps_on     = 1'b0;
    run_traffic(200);
  endtask

  // Stall the report side in random bursts
  always @(negedge clk) begin
    if (gaps_on && stall_left == 0 && $urandom_range(0, 5) == 0)
      stall_left = $urandom_range(1, 6);
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      report_if.ready <= 1'b0;
    end else begin
      report_if.ready <= 1'b1;
    end
  end

  // Check each report transaction against the oldest prediction
  always @(posedge clk) begin
    fbrc_result_t seen;
    fbrc_result_t want;
    if (!rst && report_if.valid && report_if.ready) begin
      seen = {report_if.out_channel, report_if.out_source, report_if.data_byte,
              report_if.position, report_if.frame_start, report_if.frame_last,
              report_if.checksum_good, report_if.overflow, report_if.frame_length,
              report_if.hdr_byte1, report_if.hdr_byte2, report_if.hdr_byte3};
      if (pending_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected report: %s", result_text(seen));
      end else begin
        want = pending_reports.pop_front();
        if (seen !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("report mismatch\n  expected: %s\n  actual:   %s",
                     result_text(want), result_text(seen));
        end
      end
    end
  end

  // Count cycles with no transaction on either side
  always @(posedge clk) begin
    if ((stream_if.valid && stream_if.ready) || (report_if.valid && report_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("tb: failure");
    $finish;
  end

  initial begin
    rst                  = 1'b1;
    stream_if.valid      = 1'b0;
    stream_if.rx_byte    = '0;
    stream_if.channel    = '0;
    stream_if.source_tag = '0;
    report_if.ready      = 1'b0;
    cfg_wen              = 1'b0;
    cfg_index            = REG_HEAD_BYTE;
    cfg_data             = '0;
    head_cfg             = HEAD_BYTE_RST;
    end_cfg              = END_BYTE_RST;
    for (int c = 0; c < CHANNELS_DEF; c++) begin
      frame_open[c]  = 1'b0;
      frame_count[c] = 0;
      frame_sum[c]   = '0;
      last_byte[c]   = '0;
      header_ids[c]  = '0;
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    gaps_on = 1'b1;
    @(negedge clk);

    test_directed();
    test_length_limit();
    test_register_settings();
    test_random_traffic();

    // Wait out the last reports and the pipeline tail
    stream_if.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/fbrc_pkg.sv
hw/rtl/fbrc_if.sv
hw/rtl/fbrc_ram.sv
hw/rtl/fbrc_frame_step.sv
hw/rtl/framed_byte_receiver_checksum7.sv
test/testbench.sv
